// ===== rtl/rvdec_pkg.sv =====
package rvdec_pkg;

    // Major opcodes that steer immediate selection and the privilege checks.
    localparam logic [6:0] OpLui     = 7'h37;
    localparam logic [6:0] OpAuipc   = 7'h17;
    localparam logic [6:0] OpJal     = 7'h6F;
    localparam logic [6:0] OpBranch  = 7'h63;
    localparam logic [6:0] OpStore   = 7'h23;
    localparam logic [6:0] OpStoreFp = 7'h27;
    localparam logic [6:0] OpSystem  = 7'h73;

    // Privilege modes; the reserved encoding is treated as user mode.
    localparam logic [1:0] ModeU    = 2'd0;
    localparam logic [1:0] ModeS    = 2'd1;
    localparam logic [1:0] ModeRsvd = 2'd2;
    localparam logic [1:0] ModeM    = 2'd3;

    // Privileged instruction encodings held in bits 31..20.
    localparam logic [11:0] F12Ecall  = 12'h000;
    localparam logic [11:0] F12Ebreak = 12'h001;
    localparam logic [11:0] F12Uret   = 12'h002;
    localparam logic [11:0] F12Sret   = 12'h102;
    localparam logic [11:0] F12Mret   = 12'h302;
    localparam logic [11:0] F12Wfi    = 12'h105;
    localparam logic [6:0]  F7SfenceVma = 7'h09;

    // CSR addresses with special handling.
    localparam logic [11:0] CsrMtvec   = 12'h305;
    localparam logic [11:0] CsrUepc    = 12'h041;
    localparam logic [11:0] CsrSepc    = 12'h141;
    localparam logic [11:0] CsrMepc    = 12'h341;
    localparam logic [11:0] CsrMedeleg = 12'h302;
    localparam logic [11:0] CsrMideleg = 12'h303;
    localparam logic [11:0] CsrSatp    = 12'h180;
    localparam logic [11:0] CsrFflags  = 12'h001;
    localparam logic [11:0] CsrFrm     = 12'h002;
    localparam logic [11:0] CsrFcsr    = 12'h003;

    // Upper seven address bits of the two counter windows.
    localparam logic [6:0] CntLoBase = 7'b1100000;
    localparam logic [6:0] CntHiBase = 7'b1100100;

    // funct3 values.
    localparam logic [2:0] F3Priv     = 3'd0;
    localparam logic [2:0] F3Reserved = 3'd4;

    // Bit positions inside status_bits.
    localparam int StFs  = 0;
    localparam int StTvm = 1;
    localparam int StTsr = 2;
    localparam int StTw  = 3;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] orig_word;
        logic [1:0]  priv_mode;
        logic        exc_pending;
        logic [3:0]  status_bits;
        logic [31:0] m_counter_enable;
        logic [31:0] s_counter_enable;
    } t_dec_in;

    typedef struct packed {
        logic [6:0]         major_opcode;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic [2:0]         func3_field;
        logic [6:0]         func7_field;
        logic signed [31:0] immediate;
        logic [11:0]        csr_address;
        logic               illegal;
        logic [31:0]        trap_value;
        logic               skipped;
    } t_dec_out;

endpackage

// ===== rtl/rv32_decode_csr_permission_check.sv =====
// RV32 decode stage with privileged-instruction and CSR access checking.
// Each input word carries one instruction together with the current
// privilege mode, mstatus flags and the two counter-enable masks. The
// result word gives the split register and function fields, the
// sign-extended immediate chosen by opcode format, the CSR address for
// SYSTEM instructions, and an illegal flag with the original bits as trap
// value. A word marked with a pending exception is passed on with only
// its skipped flag set. The block takes one word per cycle while the
// result side does not stall; each word passes through the input register
// and then the result register, with all decoding done in the single
// logic level between them. The supervisor-present register is written
// through the configuration port and resets to one.
module rv32_decode_csr_permission_check
    import rvdec_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dec_in  i_in_word,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dec_out o_out_word
);

    logic     r_s_present;
    logic     r_in_vld;
    t_dec_in  r_in;
    logic     r_out_vld;
    t_dec_out r_out;
    t_dec_out n_out;
    logic     out_adv;
    logic     in_acc;

    // Handshake: each stage moves when the stage after it has room.
    assign out_adv    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !out_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_present <= 1'b1;
        end else if (i_cfg_we) begin
            r_s_present <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (out_adv || !r_in_vld) begin
            r_in_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
    end

    // Decode and legality checks for the word in the input register.
    always_comb begin
        logic [31:0] ir;
        logic [1:0]  mode;
        logic [11:0] f12;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rs1;
        logic        tvm;
        logic        tsr;
        logic        tw;
        logic        fs;
        logic        priv_ok;
        logic        csr_ok;
        logic        wr;
        logic [1:0]  lvl;
        logic        is_cnt;
        logic        cnt_deny;
        logic        ill;
        logic [11:0] csr;
        logic [31:0] imm;

        ir   = r_in.instr_word;
        mode = (r_in.priv_mode == ModeRsvd) ? ModeU : r_in.priv_mode;
        f12  = ir[31:20];
        f3   = ir[14:12];
        f7   = ir[31:25];
        rs1  = ir[19:15];
        fs   = r_in.status_bits[StFs];
        tvm  = r_in.status_bits[StTvm];
        tsr  = r_in.status_bits[StTsr];
        tw   = r_in.status_bits[StTw];

        // Immediate by instruction format.
        case (ir[6:0])
            OpLui, OpAuipc: imm = {ir[31:12], 12'b0};
            OpJal:          imm = {{12{ir[31]}}, ir[19:12], ir[20], ir[30:21], 1'b0};
            OpBranch:       imm = {{20{ir[31]}}, ir[7], ir[30:25], ir[11:8], 1'b0};
            OpStore, OpStoreFp: imm = {{20{ir[31]}}, ir[31:25], ir[11:7]};
            default:        imm = {{20{ir[31]}}, ir[31:20]};
        endcase

        // Privileged instruction legality.
        if (f12 inside {F12Ecall, F12Ebreak, F12Uret}) begin
            priv_ok = 1'b1;
        end else if (f12 == F12Sret) begin
            priv_ok = r_s_present && (mode != ModeU) && !((mode == ModeS) && tsr);
        end else if (f12 == F12Mret) begin
            priv_ok = (mode == ModeM);
        end else if (f12 == F12Wfi) begin
            priv_ok = (mode != ModeU) && !(tw && (mode != ModeM));
        end else if (f7 == F7SfenceVma) begin
            priv_ok = r_s_present && (mode != ModeU) && !((mode == ModeS) && tvm);
        end else begin
            priv_ok = 1'b0;
        end

        // CSR access legality.
        wr       = (f3[1:0] == 2'b01) || (rs1 != 5'd0);
        lvl      = f12[9:8];
        is_cnt   = (f12[11:5] == CntLoBase) || (f12[11:5] == CntHiBase);
        cnt_deny = !r_in.m_counter_enable[f12[4:0]] ||
                   ((mode == ModeU) && r_s_present && !r_in.s_counter_enable[f12[4:0]]);
        csr_ok   = 1'b1;
        if (mode < lvl) begin
            csr_ok = 1'b0;
        end
        if (wr && (f12[11:10] == 2'b11)) begin
            csr_ok = 1'b0;
        end
        if (!r_s_present && ((lvl == ModeS) || (f12 inside {CsrMedeleg, CsrMideleg}))) begin
            csr_ok = 1'b0;
        end
        if ((f12 == CsrSatp) && (mode == ModeS) && tvm) begin
            csr_ok = 1'b0;
        end
        if ((mode != ModeM) && is_cnt && cnt_deny) begin
            csr_ok = 1'b0;
        end
        if ((f12 inside {CsrFflags, CsrFrm, CsrFcsr}) && !fs) begin
            csr_ok = 1'b0;
        end

        // CSR address and final verdict for SYSTEM instructions.
        csr = 12'd0;
        ill = 1'b0;
        if (ir[6:0] == OpSystem) begin
            if (f3 == F3Priv) begin
                case (f12)
                    F12Ecall: csr = CsrMtvec;
                    F12Uret:  csr = CsrUepc;
                    F12Sret:  csr = CsrSepc;
                    F12Mret:  csr = CsrMepc;
                    default:  csr = 12'd0;
                endcase
                ill = !priv_ok;
            end else begin
                csr = f12;
                ill = (f3 == F3Reserved) || !csr_ok;
            end
        end

        n_out = '0;
        if (r_in.exc_pending) begin
            n_out.skipped = 1'b1;
        end else begin
            n_out.major_opcode = ir[6:0];
            n_out.dest_reg     = ir[11:7];
            n_out.src_reg_a    = rs1;
            n_out.src_reg_b    = ir[24:20];
            n_out.func3_field  = f3;
            n_out.func7_field  = f7;
            n_out.immediate    = imm;
            n_out.csr_address  = csr;
            n_out.illegal      = ill;
            n_out.trap_value   = ill ? r_in.orig_word : 32'd0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/rvdec_checker.sv =====
module rvdec_checker
    import rvdec_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_dec_out o_out_word
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result word changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Trap value is only reported on an illegal instruction.
    a_trap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.illegal) |-> (o_out_word.trap_value == 32'd0))
        else $error("trap value without illegal");

    // Only SYSTEM instructions that were decoded can be illegal.
    a_ill_system: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.illegal) |->
        ((o_out_word.major_opcode == OpSystem) && !o_out_word.skipped))
        else $error("illegal flag on a non-SYSTEM word");

    // A skipped word carries no decoded content.
    a_skip_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.skipped) |->
        ((o_out_word.major_opcode == 7'd0) && (o_out_word.csr_address == 12'd0) &&
         (o_out_word.immediate == 32'sd0)))
        else $error("skipped word has decoded fields");

endmodule

bind rv32_decode_csr_permission_check rvdec_checker u_rvdec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ===== verif/tb.sv =====
module tb;
    import rvdec_pkg::*;

    // CSR funct3 encodings and a few CSR addresses used by the directed rows.
    localparam logic [2:0]  F3Csrrw    = 3'd1;
    localparam logic [2:0]  F3Csrrs    = 3'd2;
    localparam logic [11:0] CsrMstatus = 12'h300;
    localparam logic [11:0] CsrSstatus = 12'h100;
    localparam logic [11:0] CsrCycle   = 12'hC00;

    // Ways of spacing words on either side.
    localparam int IdleNone   = 0;
    localparam int IdleRandom = 1;
    localparam int IdleRare   = 2;

    localparam int QuietLimit = 1000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    logic     i_cfg_wdata;
    logic     i_in_valid;
    logic     o_in_stall;
    t_dec_in  i_in_word;
    logic     o_out_valid;
    logic     i_out_stall;
    t_dec_out o_out_word;

    rv32_decode_csr_permission_check u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    t_dec_out decode_q[$];
    logic     smode_on;
    int       tx_style;
    int       rx_style;
    int       rx_hold_len;
    int       n_sent;
    int       n_checked;
    int       n_errors;
    int       n_cfg_writes;
    int       n_directed;

    // Directed stimulus table.
    logic     dir_smode[32];
    t_dec_in  dir_in[32];
    bit       dir_typed[32];
    t_dec_out dir_want[32];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Expected decode of one instruction word under the given S-mode setting.
    function automatic t_dec_out decode_expect(input t_dec_in w, input logic s_on);
        t_dec_out    r;
        logic [31:0] ir;
        logic [1:0]  md;
        logic [11:0] f12;
        logic [3:0]  st;
        logic        wr;
        logic        ok;
        logic [4:0]  cbit;
        logic        deny;
        r = '0;
        if (w.exc_pending) begin
            r.skipped = 1'b1;
            return r;
        end
        ir  = w.instr_word;
        st  = w.status_bits;
        md  = (w.priv_mode == ModeRsvd) ? ModeU : w.priv_mode;
        f12 = ir[31:20];
        r.major_opcode = ir[6:0];
        r.dest_reg     = ir[11:7];
        r.src_reg_a    = ir[19:15];
        r.src_reg_b    = ir[24:20];
        r.func3_field  = ir[14:12];
        r.func7_field  = ir[31:25];

        // Immediate format follows the major opcode.
        case (ir[6:0])
            OpLui, OpAuipc: r.immediate = {ir[31:12], 12'b0};
            OpJal: r.immediate = {{12{ir[31]}}, ir[19:12], ir[20], ir[30:21], 1'b0};
            OpBranch: r.immediate = {{20{ir[31]}}, ir[7], ir[30:25], ir[11:8], 1'b0};
            OpStore, OpStoreFp: r.immediate = {{20{ir[31]}}, ir[31:25], ir[11:7]};
            default: r.immediate = {{20{ir[31]}}, ir[31:20]};
        endcase

        if (ir[6:0] == OpSystem) begin
            if (ir[14:12] == F3Priv) begin
                // Privileged instructions: CSR address and legality by encoding.
                if (f12 == F12Ecall) r.csr_address = CsrMtvec;
                else if (f12 == F12Uret) r.csr_address = CsrUepc;
                else if (f12 == F12Sret) r.csr_address = CsrSepc;
                else if (f12 == F12Mret) r.csr_address = CsrMepc;
                if (f12 == F12Ecall || f12 == F12Ebreak || f12 == F12Uret)
                    ok = 1'b1;
                else if (f12 == F12Sret)
                    ok = s_on && md != ModeU && !(md == ModeS && st[StTsr]);
                else if (f12 == F12Mret)
                    ok = (md == ModeM);
                else if (f12 == F12Wfi)
                    ok = md != ModeU && !(st[StTw] && md != ModeM);
                else if (ir[31:25] == F7SfenceVma)
                    ok = s_on && md != ModeU && !(md == ModeS && st[StTvm]);
                else
                    ok = 1'b0;
            end else begin
                // CSR access checks.
                wr = (ir[13:12] == 2'b01) || (ir[19:15] != 5'd0);
                r.csr_address = f12;
                ok = (ir[14:12] != F3Reserved);
                if (md < f12[9:8])
                    ok = 1'b0;
                if (wr && f12[11:10] == 2'b11)
                    ok = 1'b0;
                if (!s_on && (f12[9:8] == 2'b01 || f12 == CsrMedeleg || f12 == CsrMideleg))
                    ok = 1'b0;
                if (f12 == CsrSatp && md == ModeS && st[StTvm])
                    ok = 1'b0;
                if (md != ModeM && (f12[11:5] == CntLoBase || f12[11:5] == CntHiBase)) begin
                    cbit = f12[4:0];
                    deny = !w.m_counter_enable[cbit];
                    if (md == ModeU && s_on)
                        deny = deny || !w.s_counter_enable[cbit];
                    if (deny)
                        ok = 1'b0;
                end
                if ((f12 == CsrFflags || f12 == CsrFrm || f12 == CsrFcsr) && !st[StFs])
                    ok = 1'b0;
            end
            r.illegal    = !ok;
            r.trap_value = ok ? 32'h0 : w.orig_word;
        end
        return r;
    endfunction

    function automatic t_dec_in mk_in(input logic [31:0] instr, input logic [31:0] orig,
                                      input logic [1:0] mode, input logic pend,
                                      input logic [3:0] st, input logic [31:0] mce,
                                      input logic [31:0] sce);
        t_dec_in w;
        w.instr_word       = instr;
        w.orig_word        = orig;
        w.priv_mode        = mode;
        w.exc_pending      = pend;
        w.status_bits      = st;
        w.m_counter_enable = mce;
        w.s_counter_enable = sce;
        return w;
    endfunction

    function automatic t_dec_out mk_out(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [4:0] rs2,
                                        input logic [2:0] f3, input logic [6:0] f7,
                                        input logic [31:0] imm, input logic [11:0] csr,
                                        input logic ill, input logic [31:0] tval,
                                        input logic skip);
        t_dec_out r;
        r.major_opcode = op;
        r.dest_reg     = rd;
        r.src_reg_a    = rs1;
        r.src_reg_b    = rs2;
        r.func3_field  = f3;
        r.func7_field  = f7;
        r.immediate    = imm;
        r.csr_address  = csr;
        r.illegal      = ill;
        r.trap_value   = tval;
        r.skipped      = skip;
        return r;
    endfunction

    function automatic logic [31:0] enc_sys(input logic [11:0] f12, input logic [4:0] rs1,
                                            input logic [2:0] f3);
        return {f12, rs1, f3, 5'd1, OpSystem};
    endfunction

    function automatic int draw_wait(input int style);
        if (style == IdleNone)
            return 0;
        if (style == IdleRare)
            return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        return $urandom_range(0, 19);
    endfunction

    // Random word: mostly SYSTEM instructions aimed at the checks, some other
    // formats and some raw noise.
    function automatic t_dec_in rand_word();
        t_dec_in     w;
        int          pick;
        logic [11:0] f12;
        logic [4:0]  rs1;
        logic [2:0]  f3;
        w = mk_in($urandom, $urandom, 2'($urandom_range(0, 3)),
                  ($urandom_range(0, 19) == 0), 4'($urandom_range(0, 15)),
                  ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'($urandom),
                  ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'($urandom));
        rs1  = ($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom);
        pick = $urandom_range(0, 9);
        if (pick >= 1 && pick <= 2) begin
            case ($urandom_range(0, 6))
                0: w.instr_word[6:0] = OpLui;
                1: w.instr_word[6:0] = OpAuipc;
                2: w.instr_word[6:0] = OpJal;
                3: w.instr_word[6:0] = OpBranch;
                4: w.instr_word[6:0] = OpStore;
                5: w.instr_word[6:0] = OpStoreFp;
                default: w.instr_word[6:0] = OpSystem;
            endcase
        end else if (pick >= 3 && pick <= 5) begin
            case ($urandom_range(0, 7))
                0: f12 = F12Ecall;
                1: f12 = F12Ebreak;
                2: f12 = F12Uret;
                3: f12 = F12Sret;
                4: f12 = F12Mret;
                5: f12 = F12Wfi;
                6: f12 = {F7SfenceVma, 5'($urandom)};
                default: f12 = 12'($urandom);
            endcase
            w.instr_word = {f12, 5'($urandom), F3Priv, 5'($urandom), OpSystem};
        end else if (pick >= 6) begin
            f3 = 3'($urandom_range(1, 7));
            case ($urandom_range(0, 7))
                0: f12 = 12'(CsrFflags + $urandom_range(0, 2));
                1: f12 = CsrSatp;
                2: f12 = ($urandom_range(0, 1) == 0) ? CsrMedeleg : CsrMideleg;
                3: f12 = {CntLoBase, 5'($urandom)};
                4: f12 = {CntHiBase, 5'($urandom)};
                5: f12 = {2'b11, 10'($urandom)};
                6: f12 = {2'($urandom), 2'b01, 8'($urandom)};
                default: f12 = 12'($urandom);
            endcase
            w.instr_word = {f12, rs1, f3, 5'($urandom), OpSystem};
        end
        return w;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", n_checked, msg);
        n_errors++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Offer one word after a gap and hold it until it is taken.
    task automatic send_word(input t_dec_in w, input bit typed, input t_dec_out want);
        int gap;
        gap = draw_wait(tx_style);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        decode_q.push_back(typed ? want : decode_expect(w, smode_on));
        n_sent++;
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (decode_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_smode(input logic v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        smode_on = v;
        n_cfg_writes++;
    endtask

    task automatic add_row(input logic smode, input t_dec_in w, input bit typed,
                           input t_dec_out want);
        dir_smode[n_directed] = smode;
        dir_in[n_directed]    = w;
        dir_typed[n_directed] = typed;
        dir_want[n_directed]  = want;
        n_directed++;
    endtask

    task automatic run_random(input int count, input logic smode, input int tx_s,
                              input int rx_s);
        int k;
        if (smode != smode_on) begin
            drain_results();
            write_smode(smode);
        end
        tx_style = tx_s;
        rx_style = rx_s;
        for (k = 0; k < count; k++)
            send_word(rand_word(), 1'b0, '0);
    endtask

    // Receiver: waits a drawn number of cycles before taking each word.
    initial begin : result_sink
        int n;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_len > 0) begin
                n = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                n = draw_wait(rx_style);
            end
            @(negedge i_clk);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_dec_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decode_q.size() == 0) begin
                note_mismatch("result word arrived with nothing expected");
            end else begin
                want = decode_q.pop_front();
                cmp_field("major_opcode", 32'(o_out_word.major_opcode),
                          32'(want.major_opcode));
                cmp_field("dest_reg", 32'(o_out_word.dest_reg), 32'(want.dest_reg));
                cmp_field("src_reg_a", 32'(o_out_word.src_reg_a), 32'(want.src_reg_a));
                cmp_field("src_reg_b", 32'(o_out_word.src_reg_b), 32'(want.src_reg_b));
                cmp_field("func3_field", 32'(o_out_word.func3_field),
                          32'(want.func3_field));
                cmp_field("func7_field", 32'(o_out_word.func7_field),
                          32'(want.func7_field));
                cmp_field("immediate", o_out_word.immediate, want.immediate);
                cmp_field("csr_address", 32'(o_out_word.csr_address),
                          32'(want.csr_address));
                cmp_field("illegal", 32'(o_out_word.illegal), 32'(want.illegal));
                cmp_field("trap_value", o_out_word.trap_value, want.trap_value);
                cmp_field("skipped", 32'(o_out_word.skipped), 32'(want.skipped));
            end
            n_checked++;
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no word moved for %0d cycles", QuietLimit);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int i;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        smode_on     = 1'b1;
        tx_style     = IdleRandom;
        rx_style     = IdleRandom;
        rx_hold_len  = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_cfg_writes = 0;
        n_directed   = 0;

        // Directed rows: extremes, every format, every privileged op but URET and each
        // illegal case, first with S present, then without.
        add_row(1'b1, mk_in(32'hFFFF_FFFF, 32'hFFFF_FFFF, ModeM, 1'b1, 4'hF, '1, '1),
                1'b1, mk_out('0, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, 1'b1));
        add_row(1'b1, mk_in(32'h0, 32'h0, ModeU, 1'b0, 4'h0, '0, '0),
                1'b1, mk_out('0, '0, '0, '0, '0, '0, '0, '0, 1'b0, '0, 1'b0));
        add_row(1'b1, mk_in(32'hFFFF_FFFF, 32'h0, ModeM, 1'b0, 4'hF, '1, '1),
                1'b1, mk_out(7'h7F, 5'h1F, 5'h1F, 5'h1F, 3'h7, 7'h7F, 32'hFFFF_FFFF,
                             12'h0, 1'b0, 32'h0, 1'b0));
        add_row(1'b1, mk_in(32'hFFFF_F037, 32'h1, ModeM, 1'b0, 4'h0, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(32'h8000_0017, 32'h1, ModeU, 1'b0, 4'h0, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(32'hFFFF_F06F, 32'h1, ModeS, 1'b0, 4'h0, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(32'h8000_0F63, 32'h1, ModeM, 1'b0, 4'h0, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(32'hFE00_0FA3, 32'h1, ModeM, 1'b0, 4'h0, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(32'h7E00_0F27, 32'h1, ModeM, 1'b0, 4'h0, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(F12Ecall, 5'd0, F3Priv), 32'h2, ModeU, 1'b0, 4'hF,
                            '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(F12Ebreak, 5'd0, F3Priv), 32'h2, ModeU, 1'b0, 4'hF,
                            '0, '0), 1'b0, '0);
        // Return from machine mode while in user mode.
        add_row(1'b1, mk_in(enc_sys(F12Mret, 5'd0, F3Priv), 32'hFFFF_FFFF, ModeU, 1'b0,
                            4'h0, '0, '0),
                1'b1, mk_out(OpSystem, 5'd1, 5'd0, 5'd2, F3Priv, 7'h18, 32'h302, CsrMepc,
                             1'b1, 32'hFFFF_FFFF, 1'b0));
        add_row(1'b1, mk_in(enc_sys(F12Sret, 5'd0, F3Priv), 32'h3, ModeS, 1'b0, 4'b0100,
                            '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(F12Wfi, 5'd0, F3Priv), 32'h4, ModeS, 1'b0, 4'b1000,
                            '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys({F7SfenceVma, 5'd3}, 5'd5, F3Priv), 32'h5, ModeS, 1'b0,
                            4'b0010, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(CsrMstatus, 5'd0, F3Reserved), 32'h6, ModeM, 1'b0,
                            4'h0, '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(CsrCycle, 5'd0, F3Csrrw), 32'h7, ModeM, 1'b0, 4'h0,
                            '1, '1), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(CsrCycle, 5'd0, F3Csrrs), 32'h8, ModeU, 1'b0, 4'h0,
                            '1, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(CsrSatp, 5'd0, F3Csrrs), 32'h9, ModeS, 1'b0, 4'b0010,
                            '0, '0), 1'b0, '0);
        add_row(1'b1, mk_in(enc_sys(CsrFcsr, 5'd0, F3Csrrs), 32'hA, ModeM, 1'b0, 4'b1110,
                            '0, '0), 1'b0, '0);
        // Reserved mode two reads a machine CSR as if in user mode.
        add_row(1'b1, mk_in(enc_sys(CsrMstatus, 5'd0, F3Csrrs), 32'hB, ModeRsvd, 1'b0,
                            4'h0, '0, '0), 1'b0, '0);
        add_row(1'b0, mk_in(enc_sys(F12Sret, 5'd0, F3Priv), 32'hC, ModeM, 1'b0, 4'h0,
                            '0, '0), 1'b0, '0);
        add_row(1'b0, mk_in(enc_sys(CsrSstatus, 5'd0, F3Csrrs), 32'hD, ModeM, 1'b0, 4'h0,
                            '0, '0), 1'b0, '0);
        add_row(1'b0, mk_in(enc_sys(CsrCycle, 5'd0, F3Csrrs), 32'hE, ModeU, 1'b0, 4'h0,
                            32'h1, '0), 1'b0, '0);
        add_row(1'b0, mk_in(enc_sys({F7SfenceVma, 5'd0}, 5'd0, F3Priv), 32'hF, ModeM, 1'b0,
                            4'h0, '0, '0), 1'b0, '0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table, switching the S-mode setting only when idle.
        for (i = 0; i < n_directed; i++) begin
            if (dir_smode[i] != smode_on) begin
                drain_results();
                write_smode(dir_smode[i]);
            end
            send_word(dir_in[i], dir_typed[i], dir_want[i]);
        end

        // Random phases with varied spacing on both sides.
        run_random(250, 1'b1, IdleRandom, IdleRandom);
        run_random(150, 1'b0, IdleNone, IdleNone);

        // Long receiver hold-off while the sender keeps offering words,
        // then a full pause until the block has emptied.
        rx_hold_len = 80;
        run_random(40, 1'b0, IdleNone, IdleRare);
        drain_results();

        run_random(300, 1'b1, IdleRare, IdleRandom);
        run_random(150, 1'b0, IdleRandom, IdleRare);
        run_random(100, 1'b1, IdleNone, IdleRandom);

        drain_results();
        repeat (5) @(posedge i_clk);
        $display("Decoded %0d words (%0d directed) with %0d S-mode writes;", n_sent,
                 n_directed, n_cfg_writes);
        $display("checked %0d results across privileged, CSR and immediate cases.",
                 n_checked);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
